@@ hdl/dik_pkg.sv @@
// Shared types, widths and register codes of the delta inverse kinematics block.
package dik_pkg;

    localparam int COORD_W    = 20;
    localparam int ROD_W      = 40;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_PROD_W  = 2 * DIFF_W;
    localparam int RAD_W      = SQ_PROD_W + 1;
    localparam int SQ_W       = 42;
    localparam int SQRT_STEPS = 21;
    localparam int OUT_W      = 21;
    localparam int SUM_W      = OUT_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TOWER_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOWER_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOWER_B_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOWER_B_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOWER_C_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOWER_C_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROD_SQ    = 3'd6;

    // Register contents after reset.
    localparam logic signed [COORD_W-1:0] RST_TOWER_A_X = -20'sd85755;
    localparam logic signed [COORD_W-1:0] RST_TOWER_A_Y = -20'sd49510;
    localparam logic signed [COORD_W-1:0] RST_TOWER_B_X = 20'sd85755;
    localparam logic signed [COORD_W-1:0] RST_TOWER_B_Y = -20'sd49510;
    localparam logic signed [COORD_W-1:0] RST_TOWER_C_X = 20'sd0;
    localparam logic signed [COORD_W-1:0] RST_TOWER_C_Y = 20'sd99021;
    localparam logic [ROD_W-1:0]          RST_ROD_SQ    = 40'd37754044416;

    localparam logic signed [SUM_W-1:0] OUT_MAX = 22'sd1048575;
    localparam logic signed [SUM_W-1:0] OUT_MIN = -22'sd1048576;

    typedef struct packed {
        logic signed [COORD_W-1:0] tax;
        logic signed [COORD_W-1:0] tay;
        logic signed [COORD_W-1:0] tbx;
        logic signed [COORD_W-1:0] tby;
        logic signed [COORD_W-1:0] tcx;
        logic signed [COORD_W-1:0] tcy;
        logic [ROD_W-1:0]          rod;
    } t_cfg;

    // One classified position handed from the front end to the root pipeline.
    typedef struct packed {
        logic signed [RAD_W-1:0]   rad_a;
        logic signed [RAD_W-1:0]   rad_b;
        logic signed [RAD_W-1:0]   rad_c;
        logic signed [COORD_W-1:0] z;
        logic                      bad;
    } t_item;

endpackage

@@ hdl/dik_front.sv @@
// Front end: tower offsets, squares, radicands and the reach check.
module dik_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dik_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [dik_pkg::COORD_W-1:0]    i_x,
    input  logic signed [dik_pkg::COORD_W-1:0]    i_y,
    input  logic signed [dik_pkg::COORD_W-1:0]    i_z,
    output logic                                  o_push,
    input  logic                                  i_full,
    output dik_pkg::t_item                        o_item
);

    logic en;
    logic r_v1, r_v2, r_v3;
    logic signed [dik_pkg::DIFF_W-1:0]    r_dx [3];
    logic signed [dik_pkg::DIFF_W-1:0]    r_dy [3];
    logic signed [dik_pkg::SQ_PROD_W-1:0] r_sx [3];
    logic signed [dik_pkg::SQ_PROD_W-1:0] r_sy [3];
    logic signed [dik_pkg::COORD_W-1:0]   r_z1, r_z2;
    logic signed [dik_pkg::RAD_W-1:0]     n_rad [3];
    logic signed [dik_pkg::COORD_W-1:0]   tx [3];
    logic signed [dik_pkg::COORD_W-1:0]   ty [3];
    dik_pkg::t_item                       r_item;

    assign tx[0] = i_cfg.tax;
    assign ty[0] = i_cfg.tay;
    assign tx[1] = i_cfg.tbx;
    assign ty[1] = i_cfg.tby;
    assign tx[2] = i_cfg.tcx;
    assign ty[2] = i_cfg.tcy;

    // The whole front pipeline moves when its last stage can drain.
    assign en      = !r_v3 || !i_full;
    assign o_ready = en;
    assign o_push  = r_v3 && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Radicand per tower from the registered squares.
    always_comb begin
        for (int t = 0; t < 3; t++) begin
            n_rad[t] = $signed({{(dik_pkg::RAD_W - dik_pkg::ROD_W){1'b0}}, i_cfg.rod})
                       - dik_pkg::RAD_W'(r_sx[t]) - dik_pkg::RAD_W'(r_sy[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < 3; t++) begin
                r_dx[t] <= dik_pkg::DIFF_W'(tx[t]) - dik_pkg::DIFF_W'(i_x);
                r_dy[t] <= dik_pkg::DIFF_W'(ty[t]) - dik_pkg::DIFF_W'(i_y);
                r_sx[t] <= r_dx[t] * r_dx[t];
                r_sy[t] <= r_dy[t] * r_dy[t];
            end
            r_z1         <= i_z;
            r_z2         <= r_z1;
            r_item.rad_a <= n_rad[0];
            r_item.rad_b <= n_rad[1];
            r_item.rad_c <= n_rad[2];
            r_item.z     <= r_z2;
            r_item.bad   <= n_rad[0][dik_pkg::RAD_W-1] || n_rad[1][dik_pkg::RAD_W-1]
                            || n_rad[2][dik_pkg::RAD_W-1];
        end
    end

endmodule

@@ hdl/dik_fifo.sv @@
// Short register queue between the front end and the root pipeline.
module dik_fifo #(
    parameter int DEPTH = dik_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dik_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dik_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dik_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // Pointers wrap at the depth, which need not be a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ hdl/dik_back.sv @@
// Back end: pipelined square roots, one result bit per stage, then add z and saturate.
module dik_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  dik_pkg::t_item                    i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [dik_pkg::OUT_W-1:0]  o_a,
    output logic signed [dik_pkg::OUT_W-1:0]  o_b,
    output logic signed [dik_pkg::OUT_W-1:0]  o_c,
    output logic                              o_bad
);

    localparam int S = dik_pkg::SQRT_STEPS;

    logic en;
    logic                              r_v   [S+1];
    logic                              r_bad [S+1];
    logic signed [dik_pkg::COORD_W-1:0] r_z  [S+1];
    logic [dik_pkg::SQ_W-1:0]          r_n   [S+1][3];
    logic [dik_pkg::SQ_W-1:0]          r_q   [S+1][3];
    logic signed [dik_pkg::RAD_W-1:0]  rad_in [3];
    logic signed [dik_pkg::SUM_W-1:0]  h [3];
    logic signed [dik_pkg::OUT_W-1:0]  n_out [3];
    logic                              r_out_v;
    logic signed [dik_pkg::OUT_W-1:0]  r_out [3];
    logic                              r_out_bad;

    // All stages advance together whenever the output register is free.
    assign en    = !r_out_v || i_ready;
    assign o_pop = en && !i_empty;

    assign rad_in[0] = i_item.rad_a;
    assign rad_in[1] = i_item.rad_b;
    assign rad_in[2] = i_item.rad_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= S; s++) begin
                r_v[s] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_empty;
            for (int s = 0; s < S; s++) begin
                r_v[s+1] <= r_v[s];
            end
            r_out_v <= r_v[S];
        end
    end

    // Load stage: an out of reach item runs through with a zero radicand.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad[0] <= i_item.bad;
            r_z[0]   <= i_item.z;
            for (int t = 0; t < 3; t++) begin
                r_n[0][t] <= i_item.bad ? '0
                             : dik_pkg::SQ_W'(rad_in[t][dik_pkg::ROD_W:0]);
                r_q[0][t] <= '0;
            end
        end
    end

    // One restoring square root step per stage, test bit falling by two places.
    for (genvar s = 0; s < S; s++) begin : g_step
        localparam logic [dik_pkg::SQ_W-1:0] BIT =
            dik_pkg::SQ_W'(1) << (2 * (S - 1 - s));
        logic [dik_pkg::SQ_W-1:0] trial [3];

        always_comb begin
            for (int t = 0; t < 3; t++) begin
                trial[t] = r_q[s][t] + BIT;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_bad[s+1] <= r_bad[s];
                r_z[s+1]   <= r_z[s];
                for (int t = 0; t < 3; t++) begin
                    if (r_n[s][t] >= trial[t]) begin
                        r_n[s+1][t] <= r_n[s][t] - trial[t];
                        r_q[s+1][t] <= (r_q[s][t] >> 1) + BIT;
                    end else begin
                        r_n[s+1][t] <= r_n[s][t];
                        r_q[s+1][t] <= r_q[s][t] >> 1;
                    end
                end
            end
        end
    end

    // Height is root plus z, clamped to the output range; zero when out of reach.
    always_comb begin
        for (int t = 0; t < 3; t++) begin
            h[t] = $signed({1'b0, r_q[S][t][dik_pkg::OUT_W-1:0]})
                   + dik_pkg::SUM_W'(r_z[S]);
            if (r_bad[S]) begin
                n_out[t] = '0;
            end else if (h[t] > dik_pkg::OUT_MAX) begin
                n_out[t] = dik_pkg::OUT_MAX[dik_pkg::OUT_W-1:0];
            end else if (h[t] < dik_pkg::OUT_MIN) begin
                n_out[t] = dik_pkg::OUT_MIN[dik_pkg::OUT_W-1:0];
            end else begin
                n_out[t] = h[t][dik_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < 3; t++) begin
                r_out[t] <= n_out[t];
            end
            r_out_bad <= r_bad[S];
        end
    end

    assign o_valid = r_out_v;
    assign o_a     = r_out[0];
    assign o_b     = r_out[1];
    assign o_c     = r_out[2];
    assign o_bad   = r_out_bad;

endmodule

@@ hdl/delta_inverse_kinematics.sv @@
// Top level of the delta inverse kinematics block: registers, front end, queue and back end.
// A position transaction becomes three carriage heights, floor(sqrt(rod_sq - dx^2 - dy^2)) + z,
// saturated to 21 bits, with unreachable set and all heights zero when any radicand is negative.
// The block takes one position every cycle while the result side keeps up. A position passes
// three front stages (offsets, squares, radicand), the queue, a load stage, one stage per square
// root bit (21) and the output register. The queue of FIFO_DEPTH entries lets the front end keep
// accepting for a while when the output stalls. Configuration goes through a plain write port;
// the user must write it only while no transaction is in flight; the block does not check it.
module delta_inverse_kinematics #(
    parameter int FIFO_DEPTH = dik_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dik_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dik_pkg::ROD_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [dik_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [dik_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [dik_pkg::COORD_W-1:0]   i_pos_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [dik_pkg::OUT_W-1:0]     o_carriage_a,
    output logic signed [dik_pkg::OUT_W-1:0]     o_carriage_b,
    output logic signed [dik_pkg::OUT_W-1:0]     o_carriage_c,
    output logic                                 o_unreachable
);

    dik_pkg::t_cfg  r_cfg;
    dik_pkg::t_item front_item, fifo_item;
    logic           push, full, pop, empty;

    // Configuration registers; writes to unused indexes fall through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tax <= dik_pkg::RST_TOWER_A_X;
            r_cfg.tay <= dik_pkg::RST_TOWER_A_Y;
            r_cfg.tbx <= dik_pkg::RST_TOWER_B_X;
            r_cfg.tby <= dik_pkg::RST_TOWER_B_Y;
            r_cfg.tcx <= dik_pkg::RST_TOWER_C_X;
            r_cfg.tcy <= dik_pkg::RST_TOWER_C_Y;
            r_cfg.rod <= dik_pkg::RST_ROD_SQ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dik_pkg::REG_TOWER_A_X: r_cfg.tax <= i_cfg_data[dik_pkg::COORD_W-1:0];
                dik_pkg::REG_TOWER_A_Y: r_cfg.tay <= i_cfg_data[dik_pkg::COORD_W-1:0];
                dik_pkg::REG_TOWER_B_X: r_cfg.tbx <= i_cfg_data[dik_pkg::COORD_W-1:0];
                dik_pkg::REG_TOWER_B_Y: r_cfg.tby <= i_cfg_data[dik_pkg::COORD_W-1:0];
                dik_pkg::REG_TOWER_C_X: r_cfg.tcx <= i_cfg_data[dik_pkg::COORD_W-1:0];
                dik_pkg::REG_TOWER_C_Y: r_cfg.tcy <= i_cfg_data[dik_pkg::COORD_W-1:0];
                dik_pkg::REG_ROD_SQ:    r_cfg.rod <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dik_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_x     (i_pos_x),
        .i_y     (i_pos_y),
        .i_z     (i_pos_z),
        .o_push  (push),
        .i_full  (full),
        .o_item  (front_item)
    );

    dik_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (fifo_item)
    );

    dik_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (fifo_item),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_a     (o_carriage_a),
        .o_b     (o_carriage_b),
        .o_c     (o_carriage_c),
        .o_bad   (o_unreachable)
    );

    // An out of reach result always carries zero heights.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unreachable) |->
        (o_carriage_a == '0 && o_carriage_b == '0 && o_carriage_c == '0))
        else $error("unreachable result with nonzero heights");

    // A stalled result is neither dropped nor changed.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_carriage_a) && $stable(o_unreachable)))
        else $error("stalled result changed");

    // The queue is never written while full nor read while empty.
    a_fifo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overflow or underflow");

endmodule
